@@ rtl/tcma_pkg.sv @@
package tcma_pkg;

   localparam int MAX_ITEMS     = 256;
   localparam int CORDIC_STAGES = 16;
   localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
   localparam int STG_W         = 5;

   localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
   localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
   localparam logic signed [41:0] SUM_MAX     = 42'sd549755813887;
   localparam logic signed [41:0] SUM_MIN     = -42'sd549755813888;
   localparam logic signed [43:0] NORM_LIMIT  = 44'sd274877906944;

   typedef struct packed {
      logic signed [15:0] angle;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
      logic [15:0]        weight;
      logic               last;
      logic               wmode;
   } item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_ROT,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MUL,
      B_ACC,
      B_TRIM_MAX,
      B_TRIM_MIN,
      B_CHECK,
      B_NORM,
      B_ROT,
      B_ROUND,
      B_OUT
   } back_state_type;

   function automatic logic signed [33:0] atan_q28(input logic [STG_W-1:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:  r = 34'sd210828714;
         5'd1:  r = 34'sd124459457;
         5'd2:  r = 34'sd65760959;
         5'd3:  r = 34'sd33381290;
         5'd4:  r = 34'sd16755422;
         5'd5:  r = 34'sd8385879;
         5'd6:  r = 34'sd4193963;
         5'd7:  r = 34'sd2097109;
         5'd8:  r = 34'sd1048571;
         5'd9:  r = 34'sd524287;
         5'd10: r = 34'sd262144;
         5'd11: r = 34'sd131072;
         5'd12: r = 34'sd65536;
         5'd13: r = 34'sd32768;
         5'd14: r = 34'sd16384;
         5'd15: r = 34'sd8192;
         5'd16: r = 34'sd4096;
         5'd17: r = 34'sd2048;
         5'd18: r = 34'sd1024;
         5'd19: r = 34'sd512;
         5'd20: r = 34'sd256;
         5'd21: r = 34'sd128;
         5'd22: r = 34'sd64;
         5'd23: r = 34'sd32;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
      logic signed [39:0] r;
      if (v > SUM_MAX) begin
         r = SUM_MAX[39:0];
      end else if (v < SUM_MIN) begin
         r = SUM_MIN[39:0];
      end else begin
         r = v[39:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] r;
      logic signed [15:0] o;
      r = (35'(v) + 35'sd16384) >>> 15;
      if (r > 35'sd32767) begin
         o = 16'sh7fff;
      end else if (r < -35'sd32768) begin
         o = 16'sh8000;
      end else begin
         o = r[15:0];
      end
      return o;
   endfunction

endpackage

@@ rtl/tcma_front.sv @@
module tcma_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [15:0]  in_angle,
   input  logic [15:0]         in_weight,
   input  logic                in_last,
   input  logic                wmode,
   output logic                out_valid,
   input  logic                out_ready,
   output tcma_pkg::item_type  out_item
);

   tcma_pkg::front_state_type state_ff, state_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [tcma_pkg::STG_W-1:0] stage_ff, stage_in;
   logic signed [15:0] angle_ff, angle_in;
   logic [15:0]        weight_ff, weight_in;
   logic               last_ff, last_in, wmode_ff, wmode_in;

   logic signed [33:0] z_raw, z_red, dx, dy, xs, ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcma_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      flip_ff   <= flip_in;
      stage_ff  <= stage_in;
      angle_ff  <= angle_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
      wmode_ff  <= wmode_in;
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      flip_in   = flip_ff;
      stage_in  = stage_ff;
      angle_in  = angle_ff;
      weight_in = weight_ff;
      last_in   = last_ff;
      wmode_in  = wmode_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;

      z_raw = {{2{in_angle[15]}}, in_angle, 16'd0};
      if (z_raw > tcma_pkg::PI_Q28) begin
         z_red = z_raw - tcma_pkg::TWO_PI_Q28;
      end else if (z_raw < -tcma_pkg::PI_Q28) begin
         z_red = z_raw + tcma_pkg::TWO_PI_Q28;
      end else begin
         z_red = z_raw;
      end

      dx = x_ff >>> stage_ff;
      dy = y_ff >>> stage_ff;
      xs = flip_ff ? -x_ff : x_ff;
      ys = flip_ff ? -y_ff : y_ff;

      out_item.angle  = angle_ff;
      out_item.sine   = tcma_pkg::to_q15(ys);
      out_item.cosine = tcma_pkg::to_q15(xs);
      out_item.weight = weight_ff;
      out_item.last   = last_ff;
      out_item.wmode  = wmode_ff;

      case (state_ff)
         tcma_pkg::F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               angle_in  = in_angle;
               weight_in = in_weight;
               last_in   = in_last;
               wmode_in  = wmode;
               x_in      = tcma_pkg::GAIN_Q30;
               y_in      = '0;
               stage_in  = '0;
               if (z_red > tcma_pkg::HALF_PI_Q28) begin
                  z_in    = z_red - tcma_pkg::PI_Q28;
                  flip_in = 1'b1;
               end else if (z_red < -tcma_pkg::HALF_PI_Q28) begin
                  z_in    = z_red + tcma_pkg::PI_Q28;
                  flip_in = 1'b1;
               end else begin
                  z_in    = z_red;
                  flip_in = 1'b0;
               end
               state_in = tcma_pkg::F_ROT;
            end
         end
         tcma_pkg::F_ROT: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - tcma_pkg::atan_q28(stage_ff);
            end else begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + tcma_pkg::atan_q28(stage_ff);
            end
            stage_in = stage_ff + 1'b1;
            if (stage_ff == tcma_pkg::STG_W'(tcma_pkg::CORDIC_STAGES - 1)) begin
               state_in = tcma_pkg::F_PUSH;
            end
         end
         tcma_pkg::F_PUSH: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = tcma_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = tcma_pkg::F_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/tcma_queue.sv @@
module tcma_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tcma_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tcma_pkg::item_type  pop_item
);

   tcma_pkg::item_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/tcma_back.sv @@
module tcma_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tcma_pkg::item_type  pop_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [14:0]         out_mean,
   output logic [8:0]          out_used,
   output logic                out_none,
   output logic                out_ovf
);

   tcma_pkg::back_state_type state_ff, state_in;
   tcma_pkg::item_type cur_ff, cur_in;
   logic signed [39:0] sine_total_ff, sine_total_in, cosine_total_ff, cosine_total_in;
   logic [tcma_pkg::CNT_W-1:0] count_ff, count_in;
   logic signed [15:0] largest_angle_ff, largest_angle_in, smallest_angle_ff, smallest_angle_in;
   logic signed [15:0] largest_sine_ff, largest_sine_in, largest_cosine_ff, largest_cosine_in;
   logic signed [15:0] smallest_sine_ff, smallest_sine_in;
   logic signed [15:0] smallest_cosine_ff, smallest_cosine_in;
   logic               overflow_ff, overflow_in;
   logic signed [32:0] sprod_ff, sprod_in, cprod_ff, cprod_in;
   logic signed [43:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [33:0] vz_ff, vz_in;
   logic [tcma_pkg::STG_W-1:0] stage_ff, stage_in;
   logic [8:0]         used_ff, used_in;
   logic [14:0]        mean_ff, mean_in;
   logic               none_ff, none_in;
   logic               out_valid_ff, out_valid_in;
   logic [14:0]        out_mean_ff, out_mean_in;
   logic [8:0]         out_used_ff, out_used_in;
   logic               out_none_ff, out_none_in, out_ovf_ff, out_ovf_in;

   logic signed [16:0] w;
   logic signed [43:0] ay, mx, dx, dy;
   logic signed [34:0] q_wide;
   logic signed [17:0] q;

   assign out_valid = out_valid_ff;
   assign out_mean  = out_mean_ff;
   assign out_used  = out_used_ff;
   assign out_none  = out_none_ff;
   assign out_ovf   = out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcma_pkg::B_IDLE;
         count_ff      <= '0;
         sine_total_ff <= '0;
         cosine_total_ff <= '0;
         overflow_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sine_total_ff <= sine_total_in;
         cosine_total_ff <= cosine_total_in;
         overflow_ff   <= overflow_in;
         out_valid_ff  <= out_valid_in;
      end
      cur_ff             <= cur_in;
      largest_angle_ff   <= largest_angle_in;
      smallest_angle_ff  <= smallest_angle_in;
      largest_sine_ff    <= largest_sine_in;
      largest_cosine_ff  <= largest_cosine_in;
      smallest_sine_ff   <= smallest_sine_in;
      smallest_cosine_ff <= smallest_cosine_in;
      sprod_ff           <= sprod_in;
      cprod_ff           <= cprod_in;
      vx_ff              <= vx_in;
      vy_ff              <= vy_in;
      vz_ff              <= vz_in;
      stage_ff           <= stage_in;
      used_ff            <= used_in;
      mean_ff            <= mean_in;
      none_ff            <= none_in;
      out_mean_ff        <= out_mean_in;
      out_used_ff        <= out_used_in;
      out_none_ff        <= out_none_in;
      out_ovf_ff         <= out_ovf_in;
   end

   always_comb begin
      state_in           = state_ff;
      cur_in             = cur_ff;
      sine_total_in      = sine_total_ff;
      cosine_total_in    = cosine_total_ff;
      count_in           = count_ff;
      largest_angle_in   = largest_angle_ff;
      smallest_angle_in  = smallest_angle_ff;
      largest_sine_in    = largest_sine_ff;
      largest_cosine_in  = largest_cosine_ff;
      smallest_sine_in   = smallest_sine_ff;
      smallest_cosine_in = smallest_cosine_ff;
      overflow_in        = overflow_ff;
      sprod_in           = sprod_ff;
      cprod_in           = cprod_ff;
      vx_in              = vx_ff;
      vy_in              = vy_ff;
      vz_in              = vz_ff;
      stage_in           = stage_ff;
      used_in            = used_ff;
      mean_in            = mean_ff;
      none_in            = none_ff;
      out_mean_in        = out_mean_ff;
      out_used_in        = out_used_ff;
      out_none_in        = out_none_ff;
      out_ovf_in         = out_ovf_ff;
      out_valid_in       = out_valid_ff && !out_ready;
      pop_ready          = 1'b0;

      w      = cur_ff.wmode ? {1'b0, cur_ff.weight} : 17'sd1;
      ay     = vy_ff[43] ? -vy_ff : vy_ff;
      mx     = (vx_ff > ay) ? vx_ff : ay;
      dx     = vx_ff >>> stage_ff;
      dy     = vy_ff >>> stage_ff;
      q_wide = (35'(vz_ff) + 35'sd32768) >>> 16;
      q      = q_wide[17:0];
      if (q < 18'sd0) begin
         q = q + tcma_pkg::TWO_PI_Q12;
      end else if (q >= tcma_pkg::TWO_PI_Q12) begin
         q = q - tcma_pkg::TWO_PI_Q12;
      end

      case (state_ff)
         tcma_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in = pop_item;
               if (count_ff < tcma_pkg::CNT_W'(tcma_pkg::MAX_ITEMS)) begin
                  state_in = tcma_pkg::B_MUL;
               end else begin
                  overflow_in = 1'b1;
                  state_in = pop_item.last ? tcma_pkg::B_TRIM_MAX : tcma_pkg::B_IDLE;
               end
            end
         end
         tcma_pkg::B_MUL: begin
            sprod_in = 33'(cur_ff.sine) * 33'(w);
            cprod_in = 33'(cur_ff.cosine) * 33'(w);
            state_in = tcma_pkg::B_ACC;
         end
         tcma_pkg::B_ACC: begin
            sine_total_in   = tcma_pkg::sat40(42'(sine_total_ff) + 42'(sprod_ff));
            cosine_total_in = tcma_pkg::sat40(42'(cosine_total_ff) + 42'(cprod_ff));
            if (count_ff == '0 || cur_ff.angle > largest_angle_ff) begin
               largest_angle_in  = cur_ff.angle;
               largest_sine_in   = cur_ff.sine;
               largest_cosine_in = cur_ff.cosine;
            end
            if (count_ff == '0 || cur_ff.angle < smallest_angle_ff) begin
               smallest_angle_in  = cur_ff.angle;
               smallest_sine_in   = cur_ff.sine;
               smallest_cosine_in = cur_ff.cosine;
            end
            count_in = count_ff + 1'b1;
            state_in = cur_ff.last ? tcma_pkg::B_TRIM_MAX : tcma_pkg::B_IDLE;
         end
         tcma_pkg::B_TRIM_MAX: begin
            used_in = 9'(count_ff);
            vx_in   = 44'(cosine_total_ff);
            vy_in   = 44'(sine_total_ff);
            if (!cur_ff.wmode && count_ff >= tcma_pkg::CNT_W'(2)) begin
               vx_in   = 44'(tcma_pkg::sat40(42'(cosine_total_ff) - 42'(largest_cosine_ff)));
               vy_in   = 44'(tcma_pkg::sat40(42'(sine_total_ff) - 42'(largest_sine_ff)));
               used_in = 9'(count_ff) - 9'd1;
            end
            state_in = tcma_pkg::B_TRIM_MIN;
         end
         tcma_pkg::B_TRIM_MIN: begin
            if (!cur_ff.wmode && count_ff >= tcma_pkg::CNT_W'(3)) begin
               vx_in   = 44'(tcma_pkg::sat40(42'(vx_ff) - 42'(smallest_cosine_ff)));
               vy_in   = 44'(tcma_pkg::sat40(42'(vy_ff) - 42'(smallest_sine_ff)));
               used_in = used_ff - 9'd1;
            end
            state_in = tcma_pkg::B_CHECK;
         end
         tcma_pkg::B_CHECK: begin
            mean_in = '0;
            if (vx_ff == '0 && vy_ff == '0) begin
               none_in  = 1'b1;
               state_in = tcma_pkg::B_OUT;
            end else begin
               none_in = 1'b0;
               if (vx_ff[43]) begin
                  vx_in = -vx_ff;
                  vy_in = -vy_ff;
                  vz_in = tcma_pkg::PI_Q28;
               end else begin
                  vz_in = '0;
               end
               state_in = tcma_pkg::B_NORM;
            end
         end
         tcma_pkg::B_NORM: begin
            stage_in = '0;
            if (mx < tcma_pkg::NORM_LIMIT) begin
               vx_in = vx_ff <<< 1;
               vy_in = vy_ff <<< 1;
            end else begin
               state_in = tcma_pkg::B_ROT;
            end
         end
         tcma_pkg::B_ROT: begin
            if (!vy_ff[43]) begin
               vx_in = vx_ff + dy;
               vy_in = vy_ff - dx;
               vz_in = vz_ff + tcma_pkg::atan_q28(stage_ff);
            end else begin
               vx_in = vx_ff - dy;
               vy_in = vy_ff + dx;
               vz_in = vz_ff - tcma_pkg::atan_q28(stage_ff);
            end
            stage_in = stage_ff + 1'b1;
            if (stage_ff == tcma_pkg::STG_W'(tcma_pkg::CORDIC_STAGES - 1)) begin
               state_in = tcma_pkg::B_ROUND;
            end
         end
         tcma_pkg::B_ROUND: begin
            mean_in  = q[14:0];
            state_in = tcma_pkg::B_OUT;
         end
         tcma_pkg::B_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in    = 1'b1;
               out_mean_in     = mean_ff;
               out_used_in     = used_ff;
               out_none_in     = none_ff;
               out_ovf_in      = overflow_ff;
               sine_total_in   = '0;
               cosine_total_in = '0;
               count_in        = '0;
               overflow_in     = 1'b0;
               state_in        = tcma_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = tcma_pkg::B_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/trimmed_circular_mean_angle_core.sv @@
// Circular mean of a stream of angles, optionally trimmed or weighted.
// req_: one angle (2^-12 rad) and weight per transfer; req_tlast ends the set.
// rsp_: one result per set, presented after the transfer carrying req_tlast.
// csr_: one-bit weighted_mode register; write only while the block is idle.
// Each input item passes through the front sine/cosine rotation unit, which
// takes one item at a time and is the limit on throughput; the back end
// multiplies and accumulates each item.
// After the last item the back end trims the sums in trimmed mode, checks
// them, normalises them, runs the vectoring rotation and rounds before the
// result is registered; it goes straight from the check to the output
// register when both sums are zero.
// A two-entry queue separates the front and back ends, so a new item is
// taken while the back end is still busy.
// Reset clears the running set and the register to trimmed mode.
// A stall on rsp_tready holds the result; the back end then waits for the
// output register, fills the queue, and req_tready falls.
module trimmed_circular_mean_angle_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // angle_in[15:0], weight_in[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // mean_angle[14:0], used_count[23:15]
   output logic [1:0]  rsp_tuser,   // no_direction[0], overflowed[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic               wmode_ff, wmode_in;
   logic               q_push, q_push_ready, q_pop_valid, q_pop_ready;
   tcma_pkg::item_type q_push_item, q_pop_item;
   logic [14:0]        mean;
   logic [8:0]         used;
   logic               none, ovf;

   assign csr_ready = 1'b1;
   assign wmode_in  = (csr_valid && csr_ready) ? csr_data : wmode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wmode_ff <= 1'b0;
      end else begin
         wmode_ff <= wmode_in;
      end
   end

   tcma_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  (req_tdata[15:0]),
      .in_weight (req_tdata[31:16]),
      .in_last   (req_tlast),
      .wmode     (wmode_ff),
      .out_valid (q_push),
      .out_ready (q_push_ready),
      .out_item  (q_push_item)
   );

   tcma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   tcma_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_item  (q_pop_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mean  (mean),
      .out_used  (used),
      .out_none  (none),
      .out_ovf   (ovf)
   );

   assign rsp_tdata = {used, mean};
   assign rsp_tuser = {ovf, none};

   a_no_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && none |-> mean == 15'd0)
      else $error("no_direction result with nonzero mean");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> used <= 9'(tcma_pkg::MAX_ITEMS))
      else $error("used_count beyond capacity");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> mean < 15'd25736)
      else $error("mean angle not wrapped");

   a_front_wait: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_push_ready |=> q_push)
      else $error("front dropped an item on a full queue");

endmodule
